// ===== design/binary_gcd_assert.svh =====
// Assertion macros shared by the binary GCD checker.
`ifndef BINARY_GCD_ASSERT_SVH
`define BINARY_GCD_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BGCD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("binary_gcd check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define BGCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("binary_gcd check failed");

`endif

// ===== design/bgcd_pkg.sv =====
// Shared types and constants for the binary GCD block.
package bgcd_pkg;

    localparam int unsigned FIELD_WIDTH = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COMMON,
        ST_REDUCE,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_HALVE_BOTH,
        OP_HALVE_A,
        OP_HALVE_B,
        OP_SUBTRACT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic a_zero;
        logic b_zero;
        logic a_even;
        logic b_even;
    } status_t;

endpackage

// ===== design/binary_gcd.sv =====
// Binary GCD unit: top level joining controller and datapath.
//
// Usage:
//   The operand channel takes first_value and second_value as one word
//   when operand_valid is high and operand_stall is low. The result
//   channel offers divisor, the greatest common divisor of the two
//   operands (zero only when both are zero), under result_valid; the
//   receiver holds result_stall high to keep the word waiting.
//   One word is worked on at a time: operand_stall stays high from the
//   accepting edge until the result has moved into the output register.
//   Steps: load, zero check, a halving of both per common factor of two,
//   a halving or subtract step at a time, a step to leave each of those
//   loops, then registering the result; a zero operand goes from the
//   zero check straight to the result. Each halving or subtract step
//   drops an operand bit. The iteration loop through the shared
//   subtract/halve unit sets the time taken.
//   A stalled result waits in the output register and the next operand
//   word is taken meanwhile; the following result is held back in the
//   controller until the output register frees up.
//   Reset clears the controller to idle and drops any held result.
module binary_gcd
    import bgcd_pkg::*;
#(
    parameter int unsigned OPERAND_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   operand_valid,
    output logic                   operand_stall,
    input  logic [FIELD_WIDTH-1:0] first_value,
    input  logic [FIELD_WIDTH-1:0] second_value,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [FIELD_WIDTH-1:0] divisor
);

    cmd_t    cmd;
    status_t status;

    // Sequence the algorithm from the operand flags.
    bgcd_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_stall (operand_stall),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .cmd           (cmd)
    );

    // Hold the operands, the count of shared twos and the result word.
    bgcd_datapath #(
        .W (OPERAND_WIDTH)
    ) u_datapath
    (
        .clk          (clk),
        .cmd          (cmd),
        .first_value  (first_value),
        .second_value (second_value),
        .status       (status),
        .divisor      (divisor)
    );

endmodule

// ===== design/bgcd_ctrl.sv =====
// Controller state machine for the binary GCD block.
module bgcd_ctrl
    import bgcd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    operand_valid,
    output logic    operand_stall,
    output logic    result_valid,
    input  logic    result_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;
    logic   out_free;

    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (operand_valid)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.a_zero || status.b_zero)
                    state_next = ST_FINISH;
                else
                    state_next = ST_COMMON;
            end
            ST_COMMON:
            begin
                if (!(status.a_even && status.b_even))
                    state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                if (status.b_zero)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op       = OP_HOLD;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (operand_valid)
                    cmd.op = OP_LOAD;
            end
            ST_CHECK:
            begin
                cmd.op = OP_HOLD;
            end
            ST_COMMON:
            begin
                if (status.a_even && status.b_even)
                    cmd.op = OP_HALVE_BOTH;
            end
            ST_REDUCE:
            begin
                if (status.b_zero)
                    cmd.op = OP_HOLD;
                else if (status.a_even)
                    cmd.op = OP_HALVE_A;
                else if (status.b_even)
                    cmd.op = OP_HALVE_B;
                else
                    cmd.op = OP_SUBTRACT;
            end
            ST_FINISH:
            begin
                cmd.out_load = out_free;
            end
            default: cmd.op = OP_HOLD;
        endcase
    end

    // Set on a new result, clear once the held word is taken.
    always_comb
    begin
        if (cmd.out_load)
            result_valid_next = 1'b1;
        else
            result_valid_next = result_valid_reg && result_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign operand_stall = (state_reg != ST_IDLE);
    assign result_valid  = result_valid_reg;

endmodule

// ===== design/bgcd_datapath.sv =====
// Operand registers, shared subtract/halve unit and result register.
module bgcd_datapath
    import bgcd_pkg::*;
#(
    parameter int unsigned W = 32
)
(
    input  logic                   clk,
    input  cmd_t                   cmd,
    input  logic [FIELD_WIDTH-1:0] first_value,
    input  logic [FIELD_WIDTH-1:0] second_value,
    output status_t                status,
    output logic [FIELD_WIDTH-1:0] divisor
);

    localparam int unsigned TW = $clog2(W);

    logic [W-1:0]           a_reg, a_next;
    logic [W-1:0]           b_reg, b_next;
    logic [TW-1:0]          twos_reg, twos_next;
    logic [FIELD_WIDTH-1:0] divisor_reg, divisor_next;

    logic [W-1:0]           a_load, b_load;
    logic [W-1:0]           diff_ab, diff_ba;
    logic                   a_gt_b;
    logic [W-1:0]           shifted;
    logic [FIELD_WIDTH-1:0] result_word;

    // Fit the fixed-width fields to the operand width.
    generate
        if (W <= FIELD_WIDTH)
        begin : g_narrow_in
            assign a_load = first_value[W-1:0];
            assign b_load = second_value[W-1:0];
        end
        else
        begin : g_wide_in
            assign a_load = {{(W-FIELD_WIDTH){1'b0}}, first_value};
            assign b_load = {{(W-FIELD_WIDTH){1'b0}}, second_value};
        end
    endgenerate

    assign diff_ab = a_reg - b_reg;
    assign diff_ba = b_reg - a_reg;
    assign a_gt_b  = (a_reg > b_reg);

    // b is zero at the end of the loop and twos is zero for a zero operand.
    assign shifted = (a_reg | b_reg) << twos_reg;

    generate
        if (W >= FIELD_WIDTH)
        begin : g_wide_out
            assign result_word = shifted[FIELD_WIDTH-1:0];
        end
        else
        begin : g_narrow_out
            assign result_word = {{(FIELD_WIDTH-W){1'b0}}, shifted};
        end
    endgenerate

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        twos_next = twos_reg;
        case (cmd.op)
            OP_HOLD:
            begin
                a_next = a_reg;
            end
            OP_LOAD:
            begin
                a_next    = a_load;
                b_next    = b_load;
                twos_next = '0;
            end
            OP_HALVE_BOTH:
            begin
                a_next    = a_reg >> 1;
                b_next    = b_reg >> 1;
                twos_next = twos_reg + TW'(1);
            end
            OP_HALVE_A:
            begin
                a_next = a_reg >> 1;
            end
            OP_HALVE_B:
            begin
                b_next = b_reg >> 1;
            end
            OP_SUBTRACT:
            begin
                // Both odd: keep the smaller, halve the even difference.
                if (a_gt_b)
                begin
                    a_next = b_reg;
                    b_next = diff_ab >> 1;
                end
                else
                begin
                    b_next = diff_ba >> 1;
                end
            end
            default: a_next = a_reg;
        endcase
    end

    assign divisor_next = cmd.out_load ? result_word : divisor_reg;

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        twos_reg    <= twos_next;
        divisor_reg <= divisor_next;
    end

    assign status.a_zero = (a_reg == '0);
    assign status.b_zero = (b_reg == '0);
    assign status.a_even = !a_reg[0];
    assign status.b_even = !b_reg[0];
    assign divisor       = divisor_reg;

endmodule

// ===== design/bgcd_checker.sv =====
// Port-level checker for the binary GCD unit, bound to the top level.
`include "binary_gcd_assert.svh"

module bgcd_checker
    import bgcd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   operand_valid,
    input logic                   operand_stall,
    input logic [FIELD_WIDTH-1:0] first_value,
    input logic [FIELD_WIDTH-1:0] second_value,
    input logic                   result_valid,
    input logic                   result_stall,
    input logic [FIELD_WIDTH-1:0] divisor
);

    `BGCD_ASSERT_NEXT(a_result_valid_holds, result_valid && result_stall, result_valid)
    `BGCD_ASSERT_NEXT(a_result_word_holds, result_valid && result_stall, $stable(divisor))
    `BGCD_ASSERT_NEXT(a_busy_after_accept, operand_valid && !operand_stall, operand_stall)
    `BGCD_ASSERT_NOW(a_zero_pair_fast, operand_valid && !operand_stall && first_value == '0 && second_value == '0 && !result_valid, ##3 (result_valid && divisor == '0))

endmodule

bind binary_gcd bgcd_checker u_bgcd_checker (.*);

// ===== test/tb_binary_gcd.sv =====
// Self-checking testbench for the binary GCD unit: random handshakes, Stein predictor.
`timescale 1ns / 100ps

module tb_binary_gcd;
    import bgcd_pkg::FIELD_WIDTH;

    // Overall run limits, in clock cycles.
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    // Settling time after the last divisor; leave room past the worst case per word.
    localparam int unsigned DRAIN_CYCLES  = 300;
    localparam int unsigned RANDOM_WORDS  = 1430;
    // Long receiver hold-offs, started once this many results have arrived.
    localparam int unsigned HOLD_CYCLES   = 1500;
    localparam int unsigned HOLD_FIRST_AT = 200;
    localparam int unsigned HOLD_LAST_AT  = 1000;
    localparam int unsigned MAX_REPORTS   = 10;

    typedef logic [FIELD_WIDTH-1:0] word_t;

    typedef struct {
        word_t op_a;
        word_t op_b;
    } operand_pair_t;

    typedef struct {
        word_t op_a;
        word_t op_b;
        word_t gcd;
    } gcd_entry_t;

    // Clock, reset and every block input start at a known value.
    logic  clk           = 1'b0;
    logic  rst_n         = 1'b0;
    logic  operand_valid = 1'b0;
    word_t first_value   = '0;
    word_t second_value  = '0;
    logic  result_stall  = 1'b0;
    logic  operand_stall;
    logic  result_valid;
    word_t divisor;

    // Operand words waiting to be offered, and divisors waiting to come back.
    operand_pair_t pending_pairs[$];
    gcd_entry_t    gcd_due[$];

    // Handshake outcomes seen at the last rising edge, read at the falling edge.
    logic took_operand = 1'b0;
    logic took_result  = 1'b0;

    int unsigned send_gap     = 0;
    int unsigned send_calm    = 0;
    int unsigned stall_left   = 0;
    int unsigned stall_calm   = 0;
    int unsigned hold_left    = 0;
    int unsigned hold_next_at = HOLD_FIRST_AT;
    int unsigned results_done = 0;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;

    binary_gcd dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_stall (operand_stall),
        .first_value   (first_value),
        .second_value  (second_value),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .divisor       (divisor)
    );

    always #1 clk = ~clk;

    // Predict the divisor by Stein's method: zero operands first, then strip
    // the common twos, then halve and subtract until one operand reaches zero.
    function automatic word_t stein_divisor(input word_t a_in, input word_t b_in);
        word_t       a;
        word_t       b;
        word_t       t;
        int unsigned twos;
        a    = a_in;
        b    = b_in;
        twos = 0;
        if (a == '0)
            return b;
        if (b == '0)
            return a;
        while (!a[0] && !b[0])
        begin
            a    = a >> 1;
            b    = b >> 1;
            twos = twos + 1;
        end
        while (!a[0])
            a = a >> 1;
        while (b != '0)
        begin
            while (!b[0])
                b = b >> 1;
            if (a > b)
            begin
                t = a;
                a = b;
                b = t;
            end
            b = b - a;
        end
        return a << twos;
    endfunction

    // Draw a random wait; now and then start a calm stretch with no waits.
    function automatic int unsigned pick_wait(inout int unsigned calm);
        if (calm > 0)
        begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 9);
    endfunction

    function automatic operand_pair_t random_pair();
        operand_pair_t p;
        word_t         g;
        p.op_a = $urandom;
        p.op_b = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            4, 5:
            begin
                // Shared odd or even factor with 16-bit cofactors.
                g      = $urandom_range(1, 65535);
                p.op_a = g * word_t'($urandom_range(0, 65535));
                p.op_b = g * word_t'($urandom_range(0, 65535));
            end
            6:
            begin
                // Many trailing zeros on both sides.
                p.op_a = p.op_a << $urandom_range(0, 31);
                p.op_b = p.op_b << $urandom_range(0, 31);
            end
            7:
            begin
                p.op_a = $urandom_range(0, 63);
                p.op_b = $urandom_range(0, 63);
            end
            8:
            begin
                case ($urandom_range(0, 2))
                    0: p.op_b = p.op_a;
                    1: p.op_b = '0;
                    default: p.op_a = '0;
                endcase
            end
            default:
            begin
                // Near the top of the range.
                p.op_a = ~word_t'($urandom_range(0, 255));
                p.op_b = ~word_t'($urandom_range(0, 255));
            end
        endcase
        return p;
    endfunction

    task automatic queue_pair(input word_t a, input word_t b);
        operand_pair_t p;
        p.op_a = a;
        p.op_b = b;
        pending_pairs.push_back(p);
    endtask

    // Rising edge: check the result word first, then record a new operand word.
    // The result leaving can never belong to the operand entering at the same
    // edge, so doing both here keeps the order of the due queue exact.
    always @(posedge clk)
    begin
        gcd_entry_t    due;
        operand_pair_t taken;
        if (rst_n)
        begin
            took_operand <= operand_valid && !operand_stall;
            took_result  <= result_valid && !result_stall;
            if (result_valid && !result_stall)
            begin
                results_done <= results_done + 1;
                if (gcd_due.size() == 0)
                begin
                    error_count = error_count + 1;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected result: divisor=%h", divisor);
                end
                else
                begin
                    due = gcd_due.pop_front();
                    if (divisor !== due.gcd)
                    begin
                        error_count = error_count + 1;
                        if (error_count <= MAX_REPORTS)
                            $display("divisor mismatch: a=%h b=%h expected=%h actual=%h",
                                     due.op_a, due.op_b, due.gcd, divisor);
                    end
                end
            end
            if (operand_valid && !operand_stall)
            begin
                taken.op_a = first_value;
                taken.op_b = second_value;
                due.op_a   = taken.op_a;
                due.op_b   = taken.op_b;
                due.gcd    = stein_divisor(taken.op_a, taken.op_b);
                gcd_due.push_back(due);
            end
        end
    end

    // Sender: drop valid after an accepted word, wait out the drawn gap, then
    // load the next pair. A word stays on the port unchanged while stalled.
    always @(negedge clk)
    begin
        logic          next_valid;
        operand_pair_t p;
        if (rst_n)
        begin
            next_valid = operand_valid;
            if (operand_valid && took_operand)
                next_valid = 1'b0;
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap = send_gap - 1;
                else if (pending_pairs.size() > 0)
                begin
                    p            = pending_pairs.pop_front();
                    first_value  <= p.op_a;
                    second_value <= p.op_b;
                    next_valid   = 1'b1;
                    send_gap     = pick_wait(send_calm);
                end
            end
            operand_valid <= next_valid;
        end
    end

    // Long hold-off, counted in cycles on its own: the block fills up and
    // must stall its operand channel while the sender keeps offering.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
                hold_left <= hold_left - 1;
            else if (results_done >= hold_next_at)
            begin
                hold_left    <= HOLD_CYCLES;
                hold_next_at <= (hold_next_at == HOLD_FIRST_AT) ? HOLD_LAST_AT : '1;
            end
        end
    end

    // Receiver: after each accepted result, stall for a drawn number of cycles.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (took_result)
                stall_left = pick_wait(stall_calm);
            result_stall <= (hold_left != 0) || (stall_left != 0);
            if (stall_left > 0)
                stall_left = stall_left - 1;
        end
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        operand_pair_t p;

        // Directed: zeros, equal operands, extremes, powers of two, parity mixes.
        queue_pair(32'h0000_0000, 32'h0000_0000);
        queue_pair(32'h0000_0000, 32'h1234_5678);
        queue_pair(32'h9ABC_DEF0, 32'h0000_0000);
        queue_pair(32'h0000_0000, 32'hFFFF_FFFF);
        queue_pair(32'hFFFF_FFFF, 32'h0000_0000);
        queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_pair(32'hFFFF_FFFF, 32'h0000_0001);
        queue_pair(32'h0000_0001, 32'hFFFF_FFFF);
        queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        queue_pair(32'hFFFF_FFFE, 32'hFFFF_FFFE);
        queue_pair(32'h8000_0000, 32'h8000_0000);
        queue_pair(32'h8000_0000, 32'h4000_0000);
        queue_pair(32'h8000_0000, 32'h0000_0001);
        queue_pair(32'h0000_0001, 32'h0000_0001);
        queue_pair(32'h0000_000C, 32'h0000_0012);
        queue_pair(32'h0000_0010, 32'h0000_0007);
        queue_pair(32'h0000_0015, 32'h0000_000E);
        // Consecutive Fibonacci numbers drive long subtract chains.
        queue_pair(32'd2971215073, 32'd1836311903);
        queue_pair(32'd1836311903, 32'd2971215073);
        queue_pair(32'hAAAA_AAAA, 32'h5555_5555);
        queue_pair(32'h5555_5555, 32'hAAAA_AAAA);
        queue_pair(32'hFFFF_0000, 32'h0000_FFFF);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            p = random_pair();
            pending_pairs.push_back(p);
        end

        // Hold reset, then release it on a falling edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // All operand words taken, all divisors back, then let the block settle.
        wait (pending_pairs.size() == 0 && !operand_valid);
        wait (gcd_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && gcd_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/bgcd_pkg.sv
design/bgcd_ctrl.sv
design/bgcd_datapath.sv
design/binary_gcd.sv
design/bgcd_checker.sv
test/tb_binary_gcd.sv
